>>> hw/rtl/csar_pkg.sv
// Package for the character scan-line renderer: constants, codes and the stage-1 type.
`timescale 1ns / 1ps

package csar_pkg;

  localparam int FONT_ENTRIES = 4096;
  localparam int FONT_AW      = $clog2(FONT_ENTRIES);
  localparam int FONT_DW      = 8;
  localparam int PIX_SLOTS    = 20;
  localparam int PIX_W        = 2 * PIX_SLOTS;

  localparam logic [0:0] FUNC_LOAD   = 1'b0;
  localparam logic [0:0] FUNC_RENDER = 1'b1;

  localparam logic [2:0] CFG_REVERSE_FIELD   = 3'd0;
  localparam logic [2:0] CFG_BASIC_ATTRIBUTE = 3'd1;
  localparam logic [2:0] CFG_BLINK_PHASE     = 3'd2;
  localparam logic [2:0] CFG_WIDE_COLUMNS    = 3'd3;
  localparam logic [2:0] CFG_LINE_DOUBLER    = 3'd4;

  localparam logic [1:0] LT_DBL_BOTTOM = 2'd0;
  localparam logic [1:0] LT_DBL_WIDTH  = 2'd1;
  localparam logic [1:0] LT_DBL_TOP    = 2'd2;
  localparam logic [1:0] LT_NORMAL     = 2'd3;

  localparam logic [9:0] WRAP_ROWS_DBL = 10'd480;
  localparam logic [9:0] WRAP_ROWS     = 10'd240;
  localparam logic [4:0] LINES_DBL     = 5'd20;
  localparam logic [4:0] LINES         = 5'd10;
  localparam logic [3:0] UL_ROW        = 4'd8;
  localparam logic [7:0] FONT_ALL_ON   = 8'hff;

  localparam logic [4:0] CNT_NARROW     = 5'd10;
  localparam logic [4:0] CNT_WIDE       = 5'd9;
  localparam logic [4:0] CNT_DBL_NARROW = 5'd20;
  localparam logic [4:0] CNT_DBL_WIDE   = 5'd18;

  typedef struct packed {
    logic [8:0]  row_y;
    logic        repeat_next_row;
    logic [11:0] x_start;
    logic [4:0]  pixel_count;
    logic        dbl;
    logic [1:0]  fg;
    logic [1:0]  bg;
    logic        blank;
    logic        blank_val;
    logic        ul_fg;
    logic        ul_zero;
  } csar_s1_t;

endpackage

>>> hw/rtl/char_scanline_attribute_renderer_core.sv
// Top level of the character scan-line renderer with attribute handling.
// An accepted render item passes through the stage-1 register and then the output register, where out_valid rises.
// Throughput: one item per cycle while out_stall does not hold the output; set by the single read port of the font RAM.
// Load items write the font RAM at acceptance and give no result.
// Reset clears the pipeline valids and the mode registers but sets the line doubler; the font RAM is not cleared.
`timescale 1ns / 1ps

module char_scanline_attribute_renderer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_data,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_char_col,
  input  logic [5:0]  in_char_row,
  input  logic [3:0]  in_char_attr,
  input  logic        in_blank,
  input  logic [1:0]  in_line_type,
  input  logic        in_in_scroll_region,
  input  logic [3:0]  in_scroll_offset,
  input  logic [4:0]  in_cell_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_row_y,
  output logic        out_repeat_next_row,
  output logic [11:0] out_x_start,
  output logic [4:0]  out_pixel_count,
  output logic [39:0] out_pixels
);

  import csar_pkg::*;

  function automatic logic [FONT_AW-1:0] font_wrap(input logic [11:0] a);
    logic [12:0] ae;
    logic [12:0] ar;
    ae = {1'b0, a};
    ar = (ae >= 13'(FONT_ENTRIES)) ? (ae - 13'(FONT_ENTRIES)) : ae;
    return ar[FONT_AW-1:0];
  endfunction

  logic reverse_field_r, basic_attribute_r, blink_phase_r, wide_columns_r, line_doubler_r;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  csar_s1_t s1_r, s1_nxt;
  logic [8:0]       out_row_y_r;
  logic             out_repeat_r;
  logic [11:0]      out_x_start_r;
  logic [4:0]       out_count_r;
  logic [PIX_W-1:0] out_pixels_r, pixels_nxt;

  logic out_free, s1_adv, s1_free, in_fire, render_ok, load_ok;
  logic [FONT_DW-1:0] ram_rdata;
  logic [FONT_AW-1:0] rd_addr;

  logic [3:0] off;
  logic [4:0] g_sl;
  logic [5:0] fi_raw;
  logic       wrap;
  logic [3:0] thr4;
  logic [4:0] thr5;
  logic [5:0] extra, ext_adj, fi_w;
  logic [9:0] cpos, y_sel;
  logic       above;
  logic [3:0] fi, jb, jrow;
  logic       in_range, dbl;
  logic [1:0] fg0, fg1, bgi, fg_f, bg_f;
  logic       invert, ul_hit;
  logic [11:0] x_base;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_stall  = !s1_free;
  assign in_fire   = in_valid && s1_free;
  assign in_range  = in_cell_line < (line_doubler_r ? LINES_DBL : LINES);
  assign render_ok = in_fire && (in_func == FUNC_RENDER) && in_range;
  assign load_ok   = in_fire && (in_func == FUNC_LOAD);

  assign s1_valid_nxt  = render_ok || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  // Font row, scroll wrap and pixel row
  always_comb begin
    off     = in_in_scroll_region ? in_scroll_offset : 4'd0;
    g_sl    = line_doubler_r ? (in_cell_line >> 1) : in_cell_line;
    fi_raw  = 6'(g_sl) + 6'(off);
    wrap    = fi_raw > 6'd9;
    thr4    = (off >= 4'd10) ? 4'd0 : (4'd10 - off);
    thr5    = line_doubler_r ? {thr4, 1'b0} : {1'b0, thr4};
    extra   = 6'(in_cell_line) + 6'd1 - 6'(thr5);
    ext_adj = line_doubler_r ? (extra >> 1) : extra;
    fi_w    = 6'(off) - ext_adj;
    cpos    = 10'({in_char_row, 3'b000}) + 10'({in_char_row, 1'b0});
    above   = cpos < 10'(extra);
    if (!wrap) begin
      fi    = fi_raw[3:0];
      y_sel = cpos + 10'(in_cell_line);
    end else if (!above) begin
      fi    = fi_w[3:0];
      y_sel = cpos - 10'(extra);
    end else begin
      fi    = 4'd0;
      y_sel = (line_doubler_r ? WRAP_ROWS_DBL : WRAP_ROWS) - 10'(extra);
    end
    unique case (in_line_type)
      LT_DBL_BOTTOM: jb = 4'(fi[3:1]) + 4'd5;
      LT_DBL_TOP:    jb = 4'(fi[3:1]);
      default:       jb = fi;
    endcase
    jrow    = jb - 4'd1;
    rd_addr = font_wrap({in_char_code, jrow});
  end

  // Intensities, underline and geometry
  always_comb begin
    fg0    = in_char_attr[1] ? 2'd2 : 2'd3;
    fg1    = (!in_char_attr[2] && blink_phase_r) ? (fg0 - 2'd1) : fg0;
    invert = in_char_attr[0] ^ reverse_field_r ^ basic_attribute_r;
    bgi    = fg1 - 2'd1;
    if (invert) begin
      bg_f = bgi;
      fg_f = (bgi != 2'd0) ? 2'd0 : (fg1 + 2'd1);
    end else begin
      bg_f = 2'd0;
      fg_f = fg1;
    end
    ul_hit = !in_char_attr[3] && (fi == UL_ROW);
    dbl    = in_line_type != LT_NORMAL;
    x_base = 12'({in_char_col, 3'b000}) +
             (wide_columns_r ? 12'(in_char_col) : 12'({in_char_col, 1'b0}));

    s1_nxt.row_y           = y_sel[8:0];
    s1_nxt.repeat_next_row = (in_line_type == LT_DBL_BOTTOM) || (in_line_type == LT_DBL_TOP);
    s1_nxt.x_start         = dbl ? {x_base[10:0], 1'b0} : x_base;
    if (dbl) begin
      s1_nxt.pixel_count = wide_columns_r ? CNT_DBL_WIDE : CNT_DBL_NARROW;
    end else begin
      s1_nxt.pixel_count = wide_columns_r ? CNT_WIDE : CNT_NARROW;
    end
    s1_nxt.dbl       = dbl;
    s1_nxt.fg        = fg_f;
    s1_nxt.bg        = bg_f;
    s1_nxt.blank     = in_blank;
    s1_nxt.blank_val = reverse_field_r ^ basic_attribute_r;
    s1_nxt.ul_fg     = ul_hit && !invert;
    s1_nxt.ul_zero   = ul_hit && invert;
  end

  csar_ram #(
    .WIDTH(FONT_DW),
    .DEPTH(FONT_ENTRIES)
  ) u_font_ram (
    .clk  (clk),
    .we   (load_ok),
    .waddr(font_wrap(in_font_addr)),
    .wdata(in_font_data),
    .re   (render_ok),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Pixel expansion
  always_comb begin
    logic [1:0] v [8];
    logic [7:0] fbyte;
    logic [2:0] src;
    fbyte = s1_r.ul_fg ? FONT_ALL_ON : ram_rdata;
    for (int b = 0; b < 8; b++) begin
      if (s1_r.blank) begin
        v[b] = {1'b0, s1_r.blank_val};
      end else if (s1_r.ul_zero) begin
        v[b] = 2'd0;
      end else begin
        v[b] = fbyte[7-b] ? s1_r.fg : s1_r.bg;
      end
    end
    pixels_nxt = '0;
    for (int k = 0; k < PIX_SLOTS; k++) begin
      if (s1_r.dbl) begin
        src = ((k >> 1) > 7) ? 3'd7 : 3'(k >> 1);
      end else begin
        src = (k > 7) ? 3'd7 : 3'(k);
      end
      if (5'(k) < s1_r.pixel_count) begin
        pixels_nxt[2*k +: 2] = v[src];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_field_r   <= 1'b0;
      basic_attribute_r <= 1'b0;
      blink_phase_r     <= 1'b0;
      wide_columns_r    <= 1'b0;
      line_doubler_r    <= 1'b1;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REVERSE_FIELD:   reverse_field_r   <= cfg_wdata[0];
          CFG_BASIC_ATTRIBUTE: basic_attribute_r <= cfg_wdata[0];
          CFG_BLINK_PHASE:     blink_phase_r     <= cfg_wdata[0];
          CFG_WIDE_COLUMNS:    wide_columns_r    <= cfg_wdata[0];
          CFG_LINE_DOUBLER:    line_doubler_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (render_ok) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_row_y_r   <= s1_r.row_y;
      out_repeat_r  <= s1_r.repeat_next_row;
      out_x_start_r <= s1_r.x_start;
      out_count_r   <= s1_r.pixel_count;
      out_pixels_r  <= pixels_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_y           = out_row_y_r;
  assign out_repeat_next_row = out_repeat_r;
  assign out_x_start         = out_x_start_r;
  assign out_pixel_count     = out_count_r;
  assign out_pixels          = out_pixels_r;

`ifndef SYNTHESIS
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == CNT_NARROW) || (out_count_r == CNT_WIDE) ||
                    (out_count_r == CNT_DBL_NARROW) || (out_count_r == CNT_DBL_WIDE))
    else $error("illegal pixel count");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_count_r[4]) |-> (out_pixels_r[39:20] == '0))
    else $error("pixels beyond a normal cell are not zero");

  a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
    render_ok |=> s1_valid_r)
    else $error("accepted render item lost");

  a_held_font_data: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(ram_rdata)))
    else $error("font data changed under a held item");
`endif

endmodule

>>> hw/rtl/csar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module csar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> dv/csar_scanline_checker.sv
// Checker for the character scan-line renderer: predicts each rendered item and compares results.
`timescale 1ns / 1ps

module csar_scanline_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_data,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_char_col,
  input  logic [5:0]  in_char_row,
  input  logic [3:0]  in_char_attr,
  input  logic        in_blank,
  input  logic [1:0]  in_line_type,
  input  logic        in_in_scroll_region,
  input  logic [3:0]  in_scroll_offset,
  input  logic [4:0]  in_cell_line,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_row_y,
  input  logic        out_repeat_next_row,
  input  logic [11:0] out_x_start,
  input  logic [4:0]  out_pixel_count,
  input  logic [39:0] out_pixels,
  output int          fail_count,
  output int          pending
);

  import csar_pkg::*;

  typedef struct packed {
    logic [8:0]  row_y;
    logic        repeat_next_row;
    logic [11:0] x_start;
    logic [4:0]  pixel_count;
    logic [39:0] pixels;
  } scanline_t;

  logic [7:0] font_copy [FONT_ENTRIES];
  logic       rev_field;
  logic       basic_attr;
  logic       blink_on;
  logic       wide_mode;
  logic       dbl_mode;
  scanline_t  expected_lines [$];

  function automatic bit predict_scanline(
    input  logic [7:0] code,
    input  logic [7:0] col,
    input  logic [5:0] crow,
    input  logic [3:0] attr,
    input  logic       blank,
    input  logic [1:0] ltype,
    input  logic       scrolled,
    input  logic [3:0] soff,
    input  logic [4:0] sl,
    output scanline_t  r
  );
    int unsigned lines, fg, bg, bg_def, off, cpos, y, fi, extra, j, x, cnt, val, fill, t, b;
    int unsigned sli;
    logic        invert;
    logic        underline;
    logic [7:0]  fbyte;
    logic [39:0] pix;
    r = '0;
    lines = dbl_mode ? 32'(LINES_DBL) : 32'(LINES);
    sli = 32'(sl);
    if (sli >= lines) return 1'b0;

    invert = attr[0] ^ rev_field ^ basic_attr;
    fg = attr[1] ? 2 : 3;
    if (!attr[2] && blink_on) fg = fg - 1;
    bg = 0;
    if (invert) begin
      bg = fg - 1;
      if (bg != 0) fg = 0;
      else fg = fg + 1;
    end
    bg_def = bg;
    underline = !attr[3];

    off = scrolled ? 32'(soff) : 0;
    cpos = 32'(crow) * 10;
    y = cpos + sli;
    fi = (dbl_mode ? (sli >> 1) : sli) + off;
    if (fi > 9) begin
      extra = 0;
      for (t = 0; t <= sli; t++) begin
        if ((dbl_mode ? (t >> 1) : t) + off > 9) extra++;
      end
      fi = off - (dbl_mode ? (extra >> 1) : extra);
      if (cpos >= extra) begin
        y = cpos - extra;
      end else begin
        y = (dbl_mode ? 32'(WRAP_ROWS_DBL) : 32'(WRAP_ROWS)) - extra;
        fi = 0;
      end
    end

    if (ltype == LT_DBL_BOTTOM) j = (fi >> 1) + 5;
    else if (ltype == LT_DBL_TOP) j = fi >> 1;
    else j = fi;
    j = (j == 0) ? 15 : j - 1;
    fbyte = font_copy[((32'(code) << 4) + j) % FONT_ENTRIES];

    bg = bg_def;
    if (underline && fi == 32'(UL_ROW)) begin
      if (!invert) begin
        fbyte = FONT_ALL_ON;
      end else begin
        fbyte = '0;
        bg = 0;
      end
    end

    pix = '0;
    cnt = 0;
    val = 0;
    for (b = 0; b < 8; b++) begin
      if (blank) val = 32'(rev_field ^ basic_attr);
      else val = fbyte[7 - b] ? fg : bg;
      pix |= 40'(val & 3) << (2 * cnt);
      cnt++;
      if (ltype != LT_NORMAL) begin
        pix |= 40'(val & 3) << (2 * cnt);
        cnt++;
      end
    end
    if (ltype != LT_NORMAL) fill = wide_mode ? 2 : 4;
    else fill = wide_mode ? 1 : 2;
    for (t = 0; t < fill; t++) begin
      pix |= 40'(val & 3) << (2 * cnt);
      cnt++;
    end

    x = 32'(col) * (wide_mode ? 9 : 10);
    if (ltype != LT_NORMAL) x = x << 1;

    r.row_y           = y[8:0];
    r.repeat_next_row = (ltype == LT_DBL_BOTTOM) || (ltype == LT_DBL_TOP);
    r.x_start         = x[11:0];
    r.pixel_count     = cnt[4:0];
    r.pixels          = pix;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    scanline_t want;
    scanline_t got;
    if (!rst_n) begin
      rev_field  = 1'b0;
      basic_attr = 1'b0;
      blink_on   = 1'b0;
      wide_mode  = 1'b0;
      dbl_mode   = 1'b1;
      fail_count = 0;
      expected_lines.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REVERSE_FIELD:   rev_field  = cfg_wdata[0];
          CFG_BASIC_ATTRIBUTE: basic_attr = cfg_wdata[0];
          CFG_BLINK_PHASE:     blink_on   = cfg_wdata[0];
          CFG_WIDE_COLUMNS:    wide_mode  = cfg_wdata[0];
          CFG_LINE_DOUBLER:    dbl_mode   = cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got.row_y           = out_row_y;
        got.repeat_next_row = out_repeat_next_row;
        got.x_start         = out_x_start;
        got.pixel_count     = out_pixel_count;
        got.pixels          = out_pixels;
        if (expected_lines.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected item, expected none, got row %0d x %0d count %0d pixels 0x%0h",
                   $time, got.row_y, got.x_start, got.pixel_count, got.pixels);
        end else begin
          want = expected_lines.pop_front();
          check_field("row_y", 40'(want.row_y), 40'(got.row_y));
          check_field("repeat_next_row", 40'(want.repeat_next_row), 40'(got.repeat_next_row));
          check_field("x_start", 40'(want.x_start), 40'(got.x_start));
          check_field("pixel_count", 40'(want.pixel_count), 40'(got.pixel_count));
          check_field("pixels", want.pixels, got.pixels);
        end
      end

      if (in_valid && !in_stall) begin
        if (in_func == FUNC_LOAD) begin
          font_copy[in_font_addr % FONT_ENTRIES] = in_font_data;
        end else if (predict_scanline(in_char_code, in_char_col, in_char_row, in_char_attr,
                                      in_blank, in_line_type, in_in_scroll_region,
                                      in_scroll_offset, in_cell_line, want)) begin
          expected_lines.push_back(want);
        end
      end
    end
    pending = expected_lines.size();
  end

endmodule

>>> dv/char_scanline_attribute_renderer_core_tb.sv
// Testbench top for the character scan-line renderer: stimulus, mode phases and verdict.
`timescale 1ns / 1ps

module char_scanline_attribute_renderer_core_tb;
  import csar_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES       = 8;

  typedef struct {
    logic        func;
    logic [11:0] font_addr;
    logic [7:0]  font_data;
    logic [7:0]  char_code;
    logic [7:0]  char_col;
    logic [5:0]  char_row;
    logic [3:0]  char_attr;
    logic        blank;
    logic [1:0]  line_type;
    logic        in_scroll_region;
    logic [3:0]  scroll_offset;
    logic [4:0]  cell_line;
  } glyph_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [0:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [11:0] in_font_addr;
  logic [7:0]  in_font_data;
  logic [7:0]  in_char_code;
  logic [7:0]  in_char_col;
  logic [5:0]  in_char_row;
  logic [3:0]  in_char_attr;
  logic        in_blank;
  logic [1:0]  in_line_type;
  logic        in_in_scroll_region;
  logic [3:0]  in_scroll_offset;
  logic [4:0]  in_cell_line;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  out_row_y;
  logic        out_repeat_next_row;
  logic [11:0] out_x_start;
  logic [4:0]  out_pixel_count;
  logic [39:0] out_pixels;
  int          fail_count;
  int          pending;

  bit         font_written [FONT_ENTRIES];
  bit         code_listed [256];
  logic [7:0] ready_codes [$];
  bit         quiet;
  bit         cur_dbl;
  int         gap_pct;
  int         stall_pct;
  int         stall_left;
  int         cycle_count;
  int         sent;

  char_scanline_attribute_renderer_core dut (.*);

  csar_scanline_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(99) < stall_pct)
      stall_left = $urandom_range(10, 1);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic glyph_item_t noise_item();
    glyph_item_t it;
    it.func             = 1'($urandom_range(1));
    it.font_addr        = 12'($urandom_range(FONT_ENTRIES - 1));
    it.font_data        = 8'($urandom_range(255));
    it.char_code        = 8'($urandom_range(255));
    it.char_col         = 8'($urandom_range(255));
    it.char_row         = 6'($urandom_range(63));
    it.char_attr        = 4'($urandom_range(15));
    it.blank            = 1'($urandom_range(1));
    it.line_type        = 2'($urandom_range(3));
    it.in_scroll_region = 1'($urandom_range(1));
    it.scroll_offset    = 4'($urandom_range(15));
    it.cell_line        = 5'($urandom_range(31));
    return it;
  endfunction

  function automatic glyph_item_t load_item(input logic [11:0] addr, input logic [7:0] data);
    glyph_item_t it;
    it = noise_item();
    it.func      = FUNC_LOAD;
    it.font_addr = addr;
    it.font_data = data;
    return it;
  endfunction

  function automatic glyph_item_t glyph(
    input logic [7:0] code,
    input logic [7:0] col,
    input logic [5:0] crow,
    input logic [3:0] attr,
    input logic       blank,
    input logic [1:0] ltype,
    input logic       scrolled,
    input logic [3:0] soff,
    input logic [4:0] sl
  );
    glyph_item_t it;
    it = noise_item();
    it.func             = FUNC_RENDER;
    it.char_code        = code;
    it.char_col         = col;
    it.char_row         = crow;
    it.char_attr        = attr;
    it.blank            = blank;
    it.line_type        = ltype;
    it.in_scroll_region = scrolled;
    it.scroll_offset    = soff;
    it.cell_line        = sl;
    return it;
  endfunction

  function automatic glyph_item_t random_render();
    glyph_item_t it;
    it = glyph(ready_codes[$urandom_range(ready_codes.size() - 1)], 8'($urandom_range(131)),
               6'($urandom_range(49)), 4'($urandom_range(15)), $urandom_range(9) == 0,
               2'($urandom_range(3)), 1'($urandom_range(1)), 4'($urandom_range(15)),
               5'(cur_dbl ? $urandom_range(19) : $urandom_range(9)));
    if ($urandom_range(19) == 0) it.char_col = 8'($urandom_range(255));
    if ($urandom_range(19) == 0) it.char_row = 6'($urandom_range(63));
    if ($urandom_range(9) == 0) it.cell_line = 5'($urandom_range(31));
    return it;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic send(input glyph_item_t it);
    int         gap;
    int         r;
    bit         full;
    logic [7:0] code;
    gap = 0;
    if (!quiet && $urandom_range(99) < gap_pct) gap = $urandom_range(10, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_func             <= it.func;
    in_font_addr        <= it.font_addr;
    in_font_data        <= it.font_data;
    in_char_code        <= it.char_code;
    in_char_col         <= it.char_col;
    in_char_row         <= it.char_row;
    in_char_attr        <= it.char_attr;
    in_blank            <= it.blank;
    in_line_type        <= it.line_type;
    in_in_scroll_region <= it.in_scroll_region;
    in_scroll_offset    <= it.scroll_offset;
    in_cell_line        <= it.cell_line;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.func == FUNC_LOAD) begin
      font_written[it.font_addr] = 1'b1;
      code = it.font_addr[11:4];
      full = 1'b1;
      for (r = 0; r < 16; r++) full &= font_written[{code, r[3:0]}];
      if (full && !code_listed[code]) begin
        code_listed[code] = 1'b1;
        ready_codes.push_back(code);
      end
    end
    sent++;
  endtask

  task automatic load_code(input logic [7:0] code);
    int r;
    for (r = 0; r < 16; r++) send(load_item({code, r[3:0]}, 8'($urandom_range(255))));
  endtask

  task automatic hold_off();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input bit v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
  endtask

  task automatic set_modes(input bit rf, input bit ba, input bit bp, input bit wc, input bit ld);
    write_reg(CFG_REVERSE_FIELD, rf);
    write_reg(CFG_BASIC_ATTRIBUTE, ba);
    write_reg(CFG_BLINK_PHASE, bp);
    write_reg(CFG_WIDE_COLUMNS, wc);
    write_reg(CFG_LINE_DOUBLER, ld);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_dbl = ld;
  endtask

  initial begin : stimulus
    int         ph;
    int         a;
    int         roll;
    int         target;
    bit         paused;
    logic [7:0] code;
    logic [3:0] attr_set [4];

    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_REVERSE_FIELD;
    cfg_wdata           = 1'b0;
    in_valid            = 1'b0;
    in_func             = FUNC_LOAD;
    in_font_addr        = '0;
    in_font_data        = '0;
    in_char_code        = '0;
    in_char_col         = '0;
    in_char_row         = '0;
    in_char_attr        = '0;
    in_blank            = 1'b0;
    in_line_type        = LT_NORMAL;
    in_in_scroll_region = 1'b0;
    in_scroll_offset    = '0;
    in_cell_line        = '0;
    out_stall           = 1'b0;
    stall_left          = 0;
    cycle_count         = 0;
    quiet               = 1'b0;
    cur_dbl             = 1'b1;
    gap_pct             = 10;
    stall_pct           = 20;
    paused              = 1'b0;
    attr_set            = '{4'h1, 4'h2, 4'h4, 4'h8};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_code(8'h00);
    load_code(8'hff);
    load_code(8'h5a);
    load_code(8'ha5);

    send(glyph(8'h00, 8'd0, 6'd0, 4'h0, 1'b0, LT_NORMAL, 1'b0, 4'd0, 5'd0));
    send(glyph(8'hff, 8'd131, 6'd49, 4'hf, 1'b0, LT_NORMAL, 1'b0, 4'd0, 5'd19));
    for (a = 0; a < 4; a++)
      send(glyph(8'h5a, 8'd10, 6'd5, attr_set[a], 1'b0, LT_NORMAL, 1'b0, 4'd0, 5'd16));
    send(glyph(8'ha5, 8'd65, 6'd25, 4'h0, 1'b0, LT_DBL_BOTTOM, 1'b0, 4'd0, 5'd7));
    send(glyph(8'ha5, 8'd65, 6'd25, 4'h6, 1'b0, LT_DBL_WIDTH, 1'b0, 4'd0, 5'd7));
    send(glyph(8'ha5, 8'd65, 6'd25, 4'h9, 1'b0, LT_DBL_TOP, 1'b0, 4'd0, 5'd7));
    send(glyph(8'h5a, 8'd3, 6'd3, 4'h1, 1'b1, LT_NORMAL, 1'b0, 4'd0, 5'd4));
    send(glyph(8'h5a, 8'd3, 6'd3, 4'h0, 1'b0, LT_NORMAL, 1'b0, 4'd0, 5'd20));
    send(glyph(8'h5a, 8'd3, 6'd3, 4'h0, 1'b0, LT_NORMAL, 1'b0, 4'd0, 5'd31));
    send(glyph(8'hff, 8'd7, 6'd0, 4'h0, 1'b0, LT_NORMAL, 1'b1, 4'd15, 5'd19));
    send(glyph(8'hff, 8'd7, 6'd20, 4'h7, 1'b0, LT_NORMAL, 1'b1, 4'd5, 5'd12));
    send(glyph(8'h00, 8'd7, 6'd20, 4'hb, 1'b0, LT_NORMAL, 1'b0, 4'd15, 5'd3));
    send(glyph(8'ha5, 8'd255, 6'd63, 4'he, 1'b0, LT_DBL_WIDTH, 1'b1, 4'd8, 5'd10));
    send(load_item(12'hfff, 8'h00));
    send(glyph(8'hff, 8'd40, 6'd12, 4'h3, 1'b0, LT_DBL_TOP, 1'b1, 4'd15, 5'd18));

    sent = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      hold_off();
      if (ph == 0) set_modes(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      else if (ph == 1) set_modes(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      else set_modes(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      quiet     = (ph == PHASES - 1);
      gap_pct   = pick_rate();
      stall_pct = pick_rate();
      target    = (ph + 1) * RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        if (ph == 3 && !paused && sent >= target - 60) begin
          paused = 1'b1;
          hold_off();
        end
        roll = $urandom_range(99);
        if (roll < 5) begin
          code = 8'($urandom_range(255));
          load_code(code);
        end else if (roll < 12) begin
          send(load_item(12'($urandom_range(FONT_ENTRIES - 1)), 8'($urandom_range(255))));
        end else begin
          send(random_render());
        end
      end
    end

    hold_off();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> char_scanline_attribute_renderer_core.f
hw/rtl/csar_pkg.sv
hw/rtl/csar_ram.sv
hw/rtl/char_scanline_attribute_renderer_core.sv
dv/csar_scanline_checker.sv
dv/char_scanline_attribute_renderer_core_tb.sv
